### hdl/rast_pkg.sv
// Shared widths, operation codes and controller states for the range assign/sum block.
package rast_pkg;

  localparam int OP_W   = 1;
  localparam int IDX_W  = 10;
  localparam int FILL_W = 16;
  localparam int SUM_W  = 26;
  localparam int SIZE_W = 11;

  localparam logic [OP_W-1:0] OP_ASSIGN = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY  = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FILL  = 6'b000100,
    ST_SUM   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

endpackage

### hdl/rast_if.sv
// Valid/ready channel interfaces for operations, results and the size register.
interface rast_in_if import rast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  range_low;
  logic [IDX_W-1:0]  range_high;
  logic [FILL_W-1:0] fill_value;
  modport source (output valid, op, range_low, range_high, fill_value, input ready);
  modport sink   (input valid, op, range_low, range_high, fill_value, output ready);
endinterface

interface rast_out_if import rast_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] range_sum;
  logic             range_ok;
  modport source (output valid, range_sum, range_ok, input ready);
  modport sink   (input valid, range_sum, range_ok, output ready);
endinterface

interface rast_cfg_if import rast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_in_use;
  modport source (output valid, size_in_use, input ready);
  modport sink   (input valid, size_in_use, output ready);
endinterface

### hdl/rast_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rast_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/range_assign_sum_tree.sv
// Range assign / range sum engine over an element memory.
//
// Channels: in_chan carries one operation per beat (op, range_low, range_high,
// fill_value); out_chan returns one beat per operation (range_sum, range_ok);
// cfg_chan writes size_in_use and is always ready. Write it only when idle.
// A range with high below low, or high at or past the size in use (capped at
// MAX_ENTRIES), is rejected: nothing changes, range_ok is 0 and the sum is 0.
// Elements live in one RAM of MAX_ENTRIES words with a registered read.
// An assign writes one element per cycle, then the result beat. A query
// streams one read per cycle into an accumulator, then the result beat. A
// rejected operation goes straight to the result beat.
// After reset the block sweeps all MAX_ENTRIES words of the RAM to zero, one
// word per cycle; in_chan.ready stays low during the sweep.
// The result is held in an output register until out_chan accepts it; no new
// operation is taken while a result waits.
module range_assign_sum_tree
  import rast_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  rast_cfg_if.sink   cfg_chan,
  rast_in_if.sink    in_chan,
  rast_out_if.source out_chan
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     hi_r, hi_nxt;
  logic [VALUE_BITS-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic              ok_r, ok_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [SIZE_W-1:0] size_r;

  logic [CW-1:0]     lo_x, hi_x, size_x, eff_size;
  logic              reject, in_fire;
  logic              we;
  logic [VALUE_BITS-1:0] wdata, rdata;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_chan.valid) begin
      size_r <= cfg_chan.size_in_use;
    end
  end

  assign lo_x     = CW'(in_chan.range_low);
  assign hi_x     = CW'(in_chan.range_high);
  assign size_x   = CW'(size_r);
  assign eff_size = (size_x > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : size_x;
  assign reject   = (hi_x < lo_x) || (hi_x >= eff_size);

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid     = (state_r == ST_OUT);
  assign out_chan.range_sum = acc_r;
  assign out_chan.range_ok  = ok_r;

  assign we    = (state_r == ST_CLEAR) || (state_r == ST_FILL);
  assign wdata = (state_r == ST_FILL) ? fill_r : '0;

  rast_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_elem_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    hi_nxt     = hi_r;
    fill_nxt   = fill_r;
    acc_nxt    = acc_r;
    ok_nxt     = ok_r;
    rd_vld_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        idx_nxt = idx_r + AW'(1);
        if (idx_r == AW'(MAX_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          acc_nxt  = '0;
          idx_nxt  = lo_x[AW-1:0];
          hi_nxt   = hi_x[AW-1:0];
          fill_nxt = VALUE_BITS'(in_chan.fill_value);
          ok_nxt   = !reject;
          if (reject) begin
            state_nxt = ST_OUT;
          end else if (in_chan.op == OP_ASSIGN) begin
            state_nxt = ST_FILL;
          end else begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_FILL: begin
        idx_nxt = idx_r + AW'(1);
        if (idx_r == hi_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_SUM: begin
        // issue one read per cycle; data lands in the next cycle
        rd_vld_nxt = 1'b1;
        if (rd_vld_r) begin
          acc_nxt = acc_r + SUM_W'(rdata);
        end
        if (idx_r == hi_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        acc_nxt   = acc_r + SUM_W'(rdata);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      idx_r    <= '0;
      ok_r     <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      ok_r     <= ok_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r   <= hi_nxt;
    fill_r <= fill_nxt;
    acc_r  <= acc_nxt;
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.range_ok |-> out_chan.range_sum == '0)
    else $error("rejected operation returned nonzero sum");

  a_no_write_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) || (state_r == ST_DRAIN) |-> !we)
    else $error("element RAM written during a query");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> idx_r <= hi_r)
    else $error("fill address ran past range end");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("operation accepted but controller stayed idle");

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> rd_vld_r)
    else $error("drain cycle without pending read data");

endmodule

### sim/tb_if.sv
// Scoreboard package: plain-array model of the block and the queue of expected result beats.
package tb_scoreboard_pkg;
  import rast_pkg::*;

  // Plain-array model of the tree with a queue of expected result beats.
  class range_sum_board;
    bit [FILL_W-1:0] elems [1024];
    bit [SIZE_W-1:0] size_reg;
    bit [SUM_W-1:0]  exp_sum [$];
    bit              exp_ok [$];
    int              errors;

    function new();
      foreach (elems[i]) elems[i] = '0;
      size_reg = SIZE_RESET;
      errors = 0;
    endfunction

    function void set_size(bit [SIZE_W-1:0] s);
      size_reg = s;
    endfunction

    function void note_op(bit [OP_W-1:0] op, bit [IDX_W-1:0] lo, bit [IDX_W-1:0] hi,
                          bit [FILL_W-1:0] fill);
      int unsigned eff;
      bit [SUM_W-1:0] acc;
      eff = (size_reg > 1024) ? 1024 : size_reg;
      acc = '0;
      if (hi < lo || hi >= eff) begin
        exp_sum.insert(exp_sum.size(), '0);
        exp_ok.insert(exp_ok.size(), 1'b0);
        return;
      end
      for (int i = lo; i <= hi; i++) begin
        if (op == OP_ASSIGN) elems[i] = fill;
        else acc += elems[i];
      end
      exp_sum.insert(exp_sum.size(), acc);
      exp_ok.insert(exp_ok.size(), 1'b1);
    endfunction

    function void check_result(bit [SUM_W-1:0] s, bit ok);
      bit [SUM_W-1:0] es;
      bit eo;
      if (exp_sum.size() == 0) begin
        $display("%0t: unexpected result beat sum=%0d ok=%0b", $time, s, ok);
        errors++;
        return;
      end
      es = exp_sum.pop_front();
      eo = exp_ok.pop_front();
      if (es !== s) begin
        $display("%0t: range_sum mismatch expected %0d actual %0d", $time, es, s);
        errors++;
      end
      if (eo !== ok) begin
        $display("%0t: range_ok mismatch expected %0b actual %0b", $time, eo, ok);
        errors++;
      end
    endfunction

    function int pending();
      return exp_sum.size();
    endfunction
  endclass
endpackage

### sim/tb.sv
// Testbench for range_assign_sum_tree: directed and random assign/sum traffic checked against an array model.
module tb;
  import rast_pkg::*;
  import tb_scoreboard_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  rast_cfg_if cfg_chan ();
  rast_in_if  in_chan ();
  rast_out_if out_chan ();

  range_assign_sum_tree dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_chan(cfg_chan), .in_chan(in_chan), .out_chan(out_chan)
  );

  range_sum_board board = new();
  bit stim_done = 0;
  bit hold_off = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Slowest run: ~700 ops, each up to a full-range span plus stalls, plus the clearing sweep.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  task automatic write_size(bit [SIZE_W-1:0] s);
    cfg_chan.valid <= 1'b1;
    cfg_chan.size_in_use <= s;
    do @(posedge clk); while (!cfg_chan.ready);
    board.set_size(s);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Offer one operation; note it when the beat is taken. Valid stays up
  // afterward until the next gap or idle_in.
  task automatic send_op(bit [OP_W-1:0] op, bit [IDX_W-1:0] lo, bit [IDX_W-1:0] hi,
                         bit [FILL_W-1:0] fill, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.op <= op;
    in_chan.range_low <= lo;
    in_chan.range_high <= hi;
    in_chan.fill_value <= fill;
    do @(posedge clk); while (!in_chan.ready);
    board.note_op(op, lo, hi, fill);
    @(negedge clk);
  endtask

  task automatic idle_in();
    in_chan.valid <= 1'b0;
  endtask

  task automatic drain_idle();
    idle_in();
    while (board.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Mostly short ranges, a few wide ones; a small share are broken ranges.
  task automatic send_random(int n, int unsigned sz);
    bit [IDX_W-1:0] lo, hi;
    int unsigned top, span;
    top = (sz > 1024) ? 1023 : ((sz == 0) ? 0 : sz - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        lo = IDX_W'($urandom); hi = IDX_W'($urandom);
      end else begin
        lo = IDX_W'($urandom_range(0, top));
        span = ($urandom_range(0, 19) == 0) ? top : $urandom_range(0, 15);
        hi = (lo + span > top) ? IDX_W'(top) : IDX_W'(lo + span);
      end
      send_op(OP_W'($urandom_range(0, 1)), lo, hi, FILL_W'($urandom),
              ($urandom_range(0, 3) != 0));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_chan.valid = 1'b0; cfg_chan.size_in_use = '0;
    in_chan.valid = 1'b0; in_chan.op = OP_ASSIGN;
    in_chan.range_low = '0; in_chan.range_high = '0; in_chan.fill_value = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, both ops, rejected ranges
    send_op(OP_QUERY, 0, 1023, 0, 0);
    send_op(OP_ASSIGN, 0, 1023, 16'hFFFF, 0);
    send_op(OP_QUERY, 0, 1023, 0, 0);
    send_op(OP_ASSIGN, 0, 0, 16'h0000, 0);
    send_op(OP_ASSIGN, 1023, 1023, 16'h5555, 0);
    send_op(OP_ASSIGN, 341, 682, 16'hAAAA, 0);
    send_op(OP_QUERY, 0, 0, 0, 0);
    send_op(OP_QUERY, 1023, 1023, 0, 0);
    send_op(OP_QUERY, 300, 700, 0, 0);
    send_op(OP_ASSIGN, 10, 5, 16'h1234, 0);
    send_op(OP_QUERY, 10, 5, 0, 0);
    send_op(OP_QUERY, 0, 1023, 0, 0);
    drain_idle();
    write_size(11'd1);
    send_op(OP_QUERY, 0, 0, 0, 0);
    send_op(OP_QUERY, 0, 1, 0, 0);
    send_op(OP_ASSIGN, 1, 1, 16'h7, 0);
    drain_idle();
    write_size(11'd0);
    send_op(OP_QUERY, 0, 0, 0, 0);
    drain_idle();
    write_size(11'h7FF);
    send_op(OP_QUERY, 1020, 1023, 0, 0);
    drain_idle();
    write_size(11'd64);
    send_random(200, 64);
    // long hold on the result side while items keep coming
    hold_off = 1;
    send_random(10, 64);
    drain_idle();
    write_size(11'd1024);
    send_random(200, 1024);
    drain_idle();
    write_size(11'd2);
    send_random(100, 2);
    drain_idle();
    write_size(11'd300);
    send_random(100, 300);
    idle_in();
    stim_done = 1;
  end

  // Result side: random stalls, one long hold-off when asked.
  initial begin
    int g;
    bit held;
    held = 0;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        held = 1;
        out_chan.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if ($urandom_range(0, 2) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_chan.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_result(out_chan.range_sum, out_chan.range_ok);
  end

  initial begin
    wait (stim_done);
    while (board.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

### range_assign_sum_tree.f
hdl/rast_pkg.sv
hdl/rast_if.sv
hdl/rast_ram.sv
hdl/range_assign_sum_tree.sv
sim/tb_if.sv
sim/tb.sv
